// File: design/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue.
// Each macro checks on the rising clock edge and is off while reset is held.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define DEQ_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define DEQ_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: design/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants shared by the double-ended queue: the request and
// response items, operation kinds and status codes.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Default storage shape.
    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int MAX_DATA_WIDTH     = 64;

    // Fixed field widths of the items.
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Operation kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value_in;
    } deq_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } deq_rsp_t;

endpackage

// File: design/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue kept in a ring memory with a front index and a
// fill count.
// ----------------------------------------------------------------------------
// Each request item carries one operation: push front, push back, pop front,
// pop back, dump or clear. A new item can be accepted every cycle while the
// response side keeps up; a pop reads the ring memory, whose registered read
// port delivers the value in the next cycle into a pending stage ahead of
// the output register. A dump holds off new items and issues one memory read
// per stored entry, giving fill-count responses (one for an empty queue) at
// one per cycle while the response side keeps up, with last set on the back
// entry. Kinds six and seven are taken and ignored. The memory needs no
// clearing after reset: only entries inside the live window are ever read.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  deq_pkg::deq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output deq_pkg::deq_rsp_t rsp
);

    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    // Ring memory and its registered read data.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Control state.
    logic             state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] dump_off_reg, dump_off_next;

    // Pending stage: waits for the memory read data of a pop or dump.
    logic                p_valid_reg, p_valid_next;
    logic                p_from_mem_reg, p_from_mem_next;
    logic [STATUS_W-1:0] p_status_reg, p_status_next;
    logic                p_last_reg, p_last_next;

    // Output register.
    logic     out_valid_reg, out_valid_next;
    deq_rsp_t out_item_reg, out_item_next;

    logic                  accept;
    logic                  out_free;
    logic                  p_move;
    logic                  p_open;
    logic                  full;
    logic                  empty;
    logic [CNT_W-1:0]      count_m1;
    logic [CNT_W-1:0]      ring_off;
    logic [SUM_W-1:0]      ring_sum;
    logic [IDX_W-1:0]      ring_idx;
    logic [IDX_W-1:0]      front_dec;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [MAX_DATA_WIDTH-1:0] in_wide;
    logic [MAX_DATA_WIDTH-1:0] rd_wide;

    // Handshake helpers.
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign p_move    = p_valid_reg && out_free;
    assign p_open    = !p_valid_reg || out_free;
    assign req_stall = (state_reg != ST_IDLE) || !p_open;
    assign accept    = req_valid && !req_stall;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CNT_W'(1);

    // Ring offset selection and wrap of front plus offset.
    always_comb
    begin
        ring_off = '0;
        if (state_reg == ST_DUMP)
        begin
            ring_off = dump_off_reg;
        end
        else if (req.kind == KIND_PUSH_BACK)
        begin
            ring_off = count_reg;
        end
        else if (req.kind == KIND_POP_BACK)
        begin
            ring_off = count_m1;
        end
    end

    always_comb
    begin
        ring_sum = SUM_W'(front_reg) + SUM_W'(ring_off);
        if (ring_sum >= SUM_W'(DEPTH))
        begin
            ring_sum = ring_sum - SUM_W'(DEPTH);
        end
        ring_idx = ring_sum[IDX_W-1:0];
    end

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);

    // Stored word is the low bits of the zero-extended request value.
    assign in_wide = {{(MAX_DATA_WIDTH - VALUE_W){1'b0}}, req.value_in};
    assign rd_wide = MAX_DATA_WIDTH'(rd_data_reg);

    // Operation sequencer.
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        dump_off_next   = dump_off_reg;
        p_valid_next    = p_valid_reg && !p_move;
        p_from_mem_next = p_from_mem_reg;
        p_status_next   = p_status_reg;
        p_last_next     = p_last_reg;
        wr_en           = 1'b0;
        wr_addr         = ring_idx;
        rd_en           = 1'b0;
        rd_addr         = ring_idx;

        if (state_reg == ST_DUMP)
        begin
            // Walk the live window, one read per free pending slot.
            if (p_open)
            begin
                rd_en           = 1'b1;
                p_valid_next    = 1'b1;
                p_from_mem_next = 1'b1;
                p_status_next   = STATUS_OK;
                p_last_next     = (dump_off_reg == count_m1);
                dump_off_next   = dump_off_reg + CNT_W'(1);
                if (dump_off_reg == count_m1)
                begin
                    state_next = ST_IDLE;
                end
            end
        end
        else if (accept)
        begin
            p_from_mem_next = 1'b0;
            p_status_next   = STATUS_OK;
            p_last_next     = 1'b1;
            unique case (req.kind)
                KIND_PUSH_FRONT:
                begin
                    p_valid_next = 1'b1;
                    if (full)
                    begin
                        p_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_PUSH_BACK:
                begin
                    p_valid_next = 1'b1;
                    if (full)
                    begin
                        p_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_POP_FRONT:
                begin
                    p_valid_next = 1'b1;
                    if (empty)
                    begin
                        p_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en           = 1'b1;
                        p_from_mem_next = 1'b1;
                        front_next      = (front_reg == IDX_W'(DEPTH - 1)) ?
                                          '0 : front_reg + IDX_W'(1);
                        count_next      = count_m1;
                    end
                end
                KIND_POP_BACK:
                begin
                    p_valid_next = 1'b1;
                    if (empty)
                    begin
                        p_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en           = 1'b1;
                        p_from_mem_next = 1'b1;
                        count_next      = count_m1;
                    end
                end
                KIND_DUMP:
                begin
                    p_valid_next = 1'b1;
                    if (empty)
                    begin
                        p_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        // First entry now, the rest from the dump state.
                        rd_en           = 1'b1;
                        p_from_mem_next = 1'b1;
                        p_last_next     = (count_reg == CNT_W'(1));
                        dump_off_next   = CNT_W'(1);
                        if (count_reg != CNT_W'(1))
                        begin
                            state_next = ST_DUMP;
                        end
                    end
                end
                KIND_CLEAR:
                begin
                    p_valid_next = 1'b1;
                    front_next   = '0;
                    count_next   = '0;
                end
                default:
                begin
                    // Unused kinds cause no response.
                end
            endcase
        end
    end

    // Output register loads from the pending stage.
    always_comb
    begin
        out_valid_next = out_valid_reg && rsp_stall;
        out_item_next  = out_item_reg;
        if (p_move)
        begin
            out_valid_next          = 1'b1;
            out_item_next.value_out = p_from_mem_reg ? rd_wide[VALUE_W-1:0] : '0;
            out_item_next.status    = p_status_reg;
            out_item_next.last      = p_last_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            dump_off_reg  <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            dump_off_reg  <= dump_off_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        p_from_mem_reg <= p_from_mem_next;
        p_status_reg   <= p_status_next;
        p_last_reg     <= p_last_next;
        out_item_reg   <= out_item_next;
    end

    // Ring memory: one write port, one registered read port. A pop never
    // writes and a push never reads, so no access pair meets in one cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_wide[DATA_WIDTH-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Checks.
    `DEQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "fill count above depth")
    `DEQ_ASSERT_SAME(a_dump_blocks, state_reg == ST_DUMP, req_stall, "item taken during dump")
    `DEQ_ASSERT_SAME(a_dump_off, state_reg == ST_DUMP, dump_off_reg < count_reg, "dump past back")
    `DEQ_ASSERT_NEXT(a_pend_hold, p_valid_reg && !out_free, p_valid_reg, "pending item lost")

endmodule

// File: verif/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking testbench for the bounded double-ended queue. It models the
// ring store, front index and fill count on its own, works out the responses
// of each request item as the block accepts it, and compares every accepted
// response field by field. Directed items reach the empty, full and ignored
// cases first. Random push and pop runs then follow under several patterns
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int Q_DEPTH = DEFAULT_DEPTH;

    // Kinds that the block takes and ignores.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // Random items sent in each phase, not counting spare kinds.
    localparam int ITEMS_PER_PHASE = 38;
    // Cycles allowed after the last response for anything stray to show up.
    localparam int DRAIN_CYCLES = 40;

    // Mirror of the queue contents and the responses still owed by the block.
    class deque_scoreboard;
        logic signed [VALUE_W-1:0] slots [Q_DEPTH];
        int front;
        int fill;
        deq_rsp_t awaited_rsp [$];
        int errors;

        function new();
            front = 0;
            fill = 0;
            errors = 0;
        endfunction

        function void owe_response(logic signed [VALUE_W-1:0] value,
                                   logic [STATUS_W-1:0] status, logic last);
            deq_rsp_t r;
            r.value_out = value;
            r.status = status;
            r.last = last;
            awaited_rsp.push_back(r);
        endfunction

        // Applies one accepted request to the mirror and queues its responses.
        function void note_request(deq_req_t r);
            int i;
            case (r.kind)
                KIND_PUSH_FRONT:
                    if (fill == Q_DEPTH)
                    begin
                        owe_response('0, STATUS_FULL, 1'b1);
                    end
                    else
                    begin
                        front = (front + Q_DEPTH - 1) % Q_DEPTH;
                        slots[front] = r.value_in;
                        fill++;
                        owe_response('0, STATUS_OK, 1'b1);
                    end
                KIND_PUSH_BACK:
                    if (fill == Q_DEPTH)
                    begin
                        owe_response('0, STATUS_FULL, 1'b1);
                    end
                    else
                    begin
                        slots[(front + fill) % Q_DEPTH] = r.value_in;
                        fill++;
                        owe_response('0, STATUS_OK, 1'b1);
                    end
                KIND_POP_FRONT:
                    if (fill == 0)
                    begin
                        owe_response('0, STATUS_EMPTY, 1'b1);
                    end
                    else
                    begin
                        owe_response(slots[front], STATUS_OK, 1'b1);
                        front = (front + 1) % Q_DEPTH;
                        fill--;
                    end
                KIND_POP_BACK:
                    if (fill == 0)
                    begin
                        owe_response('0, STATUS_EMPTY, 1'b1);
                    end
                    else
                    begin
                        owe_response(slots[(front + fill - 1) % Q_DEPTH], STATUS_OK, 1'b1);
                        fill--;
                    end
                KIND_DUMP:
                    if (fill == 0)
                    begin
                        owe_response('0, STATUS_EMPTY, 1'b1);
                    end
                    else
                    begin
                        for (i = 0; i < fill; i++)
                        begin
                            owe_response(slots[(front + i) % Q_DEPTH], STATUS_OK,
                                         (i == fill - 1));
                        end
                    end
                KIND_CLEAR:
                begin
                    front = 0;
                    fill = 0;
                    owe_response('0, STATUS_OK, 1'b1);
                end
                default:
                begin
                    // Spare kinds leave the queue alone and answer nothing.
                end
            endcase
        endfunction

        // Compares one accepted response with the oldest one owed.
        function void check_response(deq_rsp_t r);
            deq_rsp_t want;
            if (awaited_rsp.size() == 0)
            begin
                $error("unexpected response: value_out %0d, status %0d, last %0d",
                       r.value_out, r.status, r.last);
                errors++;
                return;
            end
            want = awaited_rsp.pop_front();
            if (r.value_out !== want.value_out)
            begin
                $error("value_out: expected %0d, actual %0d", want.value_out, r.value_out);
                errors++;
            end
            if (r.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, r.status);
                errors++;
            end
            if (r.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, r.last);
                errors++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    deq_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    deq_rsp_t rsp;

    int idle_pct = 0;
    int stall_pct = 0;

    deque_scoreboard sb = new();

    double_ended_queue #(
        .DEPTH      (Q_DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Both handshakes are sampled at the same edge; requests are noted first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    // Offers one item, with random gaps first, and waits until it is taken.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            req <= {KIND_W'($urandom_range(7)), VALUE_W'($urandom)};
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req.kind <= kind;
        req.value_in <= value;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Push values lean toward the extremes of the field.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Main sequence.
    initial
    begin
        int idle_plan [4] = '{0, 45, 0, 21};
        int stall_plan [4] = '{0, 0, 45, 21};
        int push_pct;
        int sent;
        int r;
        int i;
        int p;
        logic [KIND_W-1:0] kind;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every empty answer, a spare kind, a fill to the brim,
        // both pushes when full, a full dump and a clear.
        send_item(KIND_POP_FRONT, 32'sd7);
        send_item(KIND_POP_BACK, 32'sd7);
        send_item(KIND_DUMP, 32'sd7);
        send_item(KIND_CLEAR, 32'sd7);
        send_item(KIND_SPARE_HI, 32'sh7FFF_FFFF);
        for (i = 0; i < Q_DEPTH; i++)
        begin
            case (i)
                0: send_item(KIND_PUSH_BACK, 32'sh7FFF_FFFF);
                1: send_item(KIND_PUSH_FRONT, 32'sh8000_0000);
                2: send_item(KIND_PUSH_BACK, '1);
                3: send_item(KIND_PUSH_FRONT, '0);
                default: send_item((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, $urandom);
            endcase
        end
        send_item(KIND_PUSH_FRONT, 32'sd1);
        send_item(KIND_PUSH_BACK, 32'sd2);
        send_item(KIND_DUMP, '0);
        send_item(KIND_CLEAR, '0);

        // Random runs: push-heavy or pop-heavy stretches move the fill level
        // between empty and full, with dumps, clears and spare kinds mixed in.
        push_pct = 50;
        for (p = 0; p < 4; p++)
        begin
            idle_pct = idle_plan[p];
            stall_pct = stall_plan[p];
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (sent % 16 == 0)
                begin
                    case ($urandom_range(2))
                        0: push_pct = 15;
                        1: push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                r = $urandom_range(99);
                if (r < 2)
                    kind = KIND_CLEAR;
                else if (r < 8)
                    kind = KIND_DUMP;
                else if (r < 11)
                    kind = r[0] ? KIND_SPARE_LO : KIND_SPARE_HI;
                else if ($urandom_range(99) < push_pct)
                    kind = r[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
                else
                    kind = r[0] ? KIND_POP_FRONT : KIND_POP_BACK;
                send_item(kind, (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK)
                                ? pick_value() : $urandom);
                if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI)
                    sent++;
            end
        end
        req_valid <= 1'b0;

        // Drain, then leave room for any stray response.
        while (sb.awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.awaited_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
